>>> rtl/rgb_led_fade_engine_defines.svh
// Assertion macros shared by the fade engine RTL.
// No dependencies; included by the top level only.
`ifndef RGB_LED_FADE_ENGINE_DEFINES_SVH
`define RGB_LED_FADE_ENGINE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RLFE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RLFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/rlfe_pkg.sv
// Shared types and constants of the RGB LED fade engine.
// No dependencies.
package rlfe_pkg;
	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  idx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] ticks;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] idx;
	} result_t;
endpackage

>>> rtl/rlfe_front.sv
// Front end: accepts beats, maps an out-of-range LED index to zero and queues them.
// Depends on rlfe_pkg.
module rlfe_front #(
	parameter int NUM_LEDS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rlfe_pkg::item_t in_item,
	output logic            q_valid,
	input  logic            q_ready,
	output rlfe_pkg::item_t q_item
);
	// Two-entry queue.
	rlfe_pkg::item_t mem_q [2];
	logic            wr_q, rd_q;
	logic [1:0]      cnt_q;
	rlfe_pkg::item_t norm;
	logic            push, pop;

	always_comb begin
		norm = in_item;
		if (in_item.idx > 8'(NUM_LEDS))
			norm.idx = '0;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= norm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> rtl/rlfe_div.sv
// Restoring divider, one quotient bit per cycle: 16-bit dividend and divisor.
// No dependencies.
module rlfe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [15:0] quotient
);
	logic [15:0] rem_q, quo_q, dvs_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;

	assign busy     = (cnt_q != 5'd0);
	assign quotient = quo_q;
	assign trial    = {rem_q, quo_q[15]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/rlfe_back.sv
// Back end: per-LED state, sequencer for set, tick and read; one result a beat.
// Depends on rlfe_pkg and rlfe_div.
module rlfe_back #(
	parameter int NUM_LEDS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  rlfe_pkg::item_t   q_item,
	output logic              res_valid,
	input  logic              res_ready,
	output rlfe_pkg::result_t res
);
	localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SET_LED, ST_DIV_START, ST_DIV_WAIT, ST_TICK, ST_OUT
	} state_t;

	state_t            state_q;
	rlfe_pkg::item_t   cur_q;
	logic [LW-1:0]     led_q;
	logic [1:0]        ch_q;
	logic              res_valid_q;
	rlfe_pkg::result_t res_q;
	rlfe_pkg::result_t res_d;
	logic [LW-1:0]     rd_led;

	logic [7:0]  level_q  [NUM_LEDS][3];
	logic [7:0]  target_q [NUM_LEDS][3];
	logic [15:0] remain_q [NUM_LEDS];
	logic [15:0] inc_q    [NUM_LEDS][3];
	logic [7:0]  frac_q   [NUM_LEDS][3];

	logic [7:0]  lvl, tgt, gap;
	logic        up;
	logic        div_start, div_busy;
	logic [15:0] div_quo, dvd;
	logic        last_led, led_sel;

	assign lvl  = level_q[led_q][ch_q];
	assign tgt  = cur_q.idx == 8'd0 ? (ch_q == 2'd0 ? cur_q.red :
		ch_q == 2'd1 ? cur_q.green : cur_q.blue) :
		(ch_q == 2'd0 ? cur_q.red : ch_q == 2'd1 ? cur_q.green : cur_q.blue);
	assign up   = tgt > lvl;
	assign gap  = up ? tgt - lvl : lvl - tgt;
	assign dvd  = {gap, 8'h00} - 16'd1;
	assign div_start = (state_q == ST_DIV_START);
	assign last_led  = (32'(led_q) == NUM_LEDS - 1);
	assign led_sel   = (cur_q.idx == 8'd0) || (cur_q.idx == 8'(led_q) + 8'd1);
	assign q_ready   = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign rd_led    = LW'(cur_q.idx - 8'd1);

	// Result of the current command: levels only for a read of a real LED.
	always_comb begin
		res_d = '0;
		if (cur_q.cmd == rlfe_pkg::CMD_READ) begin
			res_d.idx = cur_q.idx;
			if (cur_q.idx != 8'd0) begin
				res_d.red   = level_q[rd_led][0];
				res_d.green = level_q[rd_led][1];
				res_d.blue  = level_q[rd_led][2];
			end
		end
	end

	rlfe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (cur_q.ticks),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			cur_q       <= '0;
			led_q       <= '0;
			ch_q        <= '0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				remain_q[i] <= '0;
				for (int c = 0; c < 3; c++) begin
					level_q[i][c]  <= '0;
					target_q[i][c] <= '0;
					inc_q[i][c]    <= '0;
					frac_q[i][c]   <= '0;
				end
			end
		end else begin
			if (res_valid_q && res_ready && state_q != ST_OUT)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						led_q <= '0;
						ch_q  <= '0;
						unique case (q_item.cmd)
							rlfe_pkg::CMD_SET:  state_q <= ST_SET_LED;
							rlfe_pkg::CMD_TICK: state_q <= ST_TICK;
							default:            state_q <= ST_OUT;
						endcase
					end
				end
				ST_SET_LED: begin
					if (!led_sel) begin
						if (last_led)
							state_q <= ST_OUT;
						led_q <= led_q + LW'(1);
					end else if (gap == 8'd0 || cur_q.ticks == 16'd0) begin
						inc_q[led_q][ch_q]    <= {15'd0, up};
						target_q[led_q][ch_q] <= tgt;
						frac_q[led_q][ch_q]   <= '0;
						remain_q[led_q]       <= cur_q.ticks;
						if (ch_q == 2'd2) begin
							ch_q <= '0;
							if (last_led)
								state_q <= ST_OUT;
							led_q <= led_q + LW'(1);
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end else begin
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (!div_busy) begin
						inc_q[led_q][ch_q]    <= {div_quo[15:1], up};
						target_q[led_q][ch_q] <= tgt;
						frac_q[led_q][ch_q]   <= '0;
						remain_q[led_q]       <= cur_q.ticks;
						state_q <= (ch_q == 2'd2 && last_led) ? ST_OUT : ST_SET_LED;
						if (ch_q == 2'd2) begin
							ch_q <= '0;
							led_q <= led_q + LW'(1);
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end
				end
				ST_TICK: begin
					// One LED a cycle, all three channels in parallel.
					if (remain_q[led_q] == 16'd0) begin
						for (int c = 0; c < 3; c++)
							level_q[led_q][c] <= target_q[led_q][c];
					end else begin
						remain_q[led_q] <= remain_q[led_q] - 16'd1;
						for (int c = 0; c < 3; c++) begin
							logic [16:0] sum;
							sum = {9'd0, frac_q[led_q][c]} + {1'b0, inc_q[led_q][c]};
							frac_q[led_q][c] <= sum[7:0];
							if (inc_q[led_q][c][0])
								level_q[led_q][c] <= level_q[led_q][c] + sum[15:8];
							else
								level_q[led_q][c] <= level_q[led_q][c] - sum[15:8];
						end
					end
					if (last_led)
						state_q <= ST_OUT;
					led_q <= led_q + LW'(1);
				end
				ST_OUT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						res_q       <= res_d;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/rgb_led_fade_engine.sv
// Top level of the RGB LED fade engine: stream ports, front queue, back sequencer.
// Depends on rlfe_pkg, rlfe_front, rlfe_back and rgb_led_fade_engine_defines.svh.
//
// Channel  Dir  Beat contents
// s_axis   in   cmd, led_index, red/green/blue targets, fade_ticks
// m_axis   out  red/green/blue levels, read_index
//
// A tick walks the LEDs, one LED per cycle. A set runs one division per channel
// of each selected LED with a nonzero gap and fade_ticks, on the one shared
// bit-serial divider (16 quotient bits a division).
// Reset is asynchronous, active low, and clears all LED state at once.
// The two-entry input queue keeps accepting beats, until it holds two, while the
// back end is busy or its result waits on m_axis_tready.
`include "rgb_led_fade_engine_defines.svh"
module rgb_led_fade_engine #(
	parameter int NUM_LEDS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] cmd, [9:2] led_index, [17:10] red_target, [25:18] green_target,
	// [33:26] blue_target, [49:34] fade_ticks, [55:50] zero
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] red_level, [15:8] green_level, [23:16] blue_level, [31:24] read_index
	output logic [31:0] m_axis_tdata
);
	rlfe_pkg::item_t   in_item, q_item;
	rlfe_pkg::result_t res;
	logic              q_valid, q_ready;

	// Unpack the input beat field by field.
	always_comb begin
		in_item.cmd   = s_axis_tdata[1:0];
		in_item.idx   = s_axis_tdata[9:2];
		in_item.red   = s_axis_tdata[17:10];
		in_item.green = s_axis_tdata[25:18];
		in_item.blue  = s_axis_tdata[33:26];
		in_item.ticks = s_axis_tdata[49:34];
	end

	rlfe_front #(.NUM_LEDS(NUM_LEDS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	rlfe_back #(.NUM_LEDS(NUM_LEDS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.idx, res.blue, res.green, res.red};

	// Every result with read index zero (a read of LED zero or any other command) has zero levels.
	`RLFE_ASSERT_IMPL(a_zero_idx, m_axis_tvalid && m_axis_tdata[31:24] == 8'd0, m_axis_tdata[23:0] == 24'd0)
	// After taking a queued beat the back end is busy for at least the next cycle.
	`RLFE_ASSERT_NEXT(a_take_leaves_idle, q_valid && q_ready, !q_ready)
	// The read index never exceeds the LED count.
	`RLFE_ASSERT_IMPL(a_idx_range, m_axis_tvalid, m_axis_tdata[31:24] <= 8'(NUM_LEDS))
endmodule

>>> sim/rgb_led_fade_engine_tb.sv
// Self-checking testbench of the RGB LED fade engine: set, tick and read beats.
// Depends on rlfe_pkg and the rgb_led_fade_engine top level.
`timescale 1ns / 100ps
module rgb_led_fade_engine_tb;
	localparam int NUM_LEDS = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 5000000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	rgb_led_fade_engine #(.NUM_LEDS(NUM_LEDS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the LED state, one entry per LED and channel (per LED for remain_q).
	logic [7:0]  level_q [NUM_LEDS][3];
	logic [7:0]  target_q [NUM_LEDS][3];
	logic [15:0] remain_q [NUM_LEDS];
	logic [15:0] step_q [NUM_LEDS][3];
	logic [7:0]  frac_q [NUM_LEDS][3];

	logic [31:0] levels_pending [$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;
	int          error_count;
	int          cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] fade_step(logic [7:0] lvl, logic [7:0] tgt,
			logic [15:0] ticks);
		logic        up;
		logic [31:0] gap;
		logic [31:0] inc;
		up = tgt > lvl;
		gap = up ? 32'(tgt - lvl) : 32'(lvl - tgt);
		inc = '0;
		if (gap != 0 && ticks != 0)
			inc = ((gap << 8) - 1) / 32'(ticks);
		inc = inc & 32'hFFFE;
		if (up)
			inc[0] = 1'b1;
		return inc[15:0];
	endfunction

	// Advances the shadow state by one beat and returns the levels beat it causes.
	function automatic logic [31:0] fade_predict(rlfe_pkg::item_t it);
		logic [7:0]  idx;
		logic [16:0] wide;
		logic [31:0] res;
		idx = (it.idx > NUM_LEDS) ? 8'd0 : it.idx;
		res = '0;
		case (it.cmd)
			rlfe_pkg::CMD_SET: begin
				for (int i = 0; i < NUM_LEDS; i++)
					if (idx == 0 || idx == i + 1) begin
						remain_q[i] = it.ticks;
						target_q[i][0] = it.red;
						target_q[i][1] = it.green;
						target_q[i][2] = it.blue;
						for (int c = 0; c < 3; c++) begin
							step_q[i][c] = fade_step(level_q[i][c], target_q[i][c], it.ticks);
							frac_q[i][c] = '0;
						end
					end
			end
			rlfe_pkg::CMD_TICK: begin
				for (int i = 0; i < NUM_LEDS; i++)
					if (remain_q[i] == 0) begin
						for (int c = 0; c < 3; c++)
							level_q[i][c] = target_q[i][c];
					end else begin
						remain_q[i]--;
						for (int c = 0; c < 3; c++) begin
							wide = 17'(frac_q[i][c]) + 17'(step_q[i][c]);
							if (step_q[i][c][0])
								level_q[i][c] = level_q[i][c] + wide[15:8];
							else
								level_q[i][c] = level_q[i][c] - wide[15:8];
							frac_q[i][c] = wide[7:0];
						end
					end
			end
			rlfe_pkg::CMD_READ: begin
				if (idx != 0)
					res[23:0] = {level_q[idx-1][2], level_q[idx-1][1], level_q[idx-1][0]};
				res[31:24] = idx;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	// Sends one beat; the levels it should cause are queued when it is accepted.
	task automatic send_beat(logic [1:0] cmd, logic [7:0] idx, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [15:0] ticks);
		rlfe_pkg::item_t it;
		it.cmd = cmd; it.idx = idx; it.red = r; it.green = g; it.blue = b;
		it.ticks = ticks;
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		s_axis_tdata = {6'd0, ticks, b, g, r, idx, cmd};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		levels_pending.push_back(fade_predict(it));
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain;
		while (levels_pending.size() != 0)
			@(negedge clk);
	endtask

	// Checks every levels beat against the oldest expectation.
	initial begin
		logic [31:0] want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (levels_pending.size() == 0) begin
					report_mismatch("unexpected beat read_index", m_axis_tdata[31:24], 8'd0);
				end else begin
					want = levels_pending.pop_front();
					if (m_axis_tdata[7:0] != want[7:0])
						report_mismatch("red_level", m_axis_tdata[7:0], want[7:0]);
					if (m_axis_tdata[15:8] != want[15:8])
						report_mismatch("green_level", m_axis_tdata[15:8], want[15:8]);
					if (m_axis_tdata[23:16] != want[23:16])
						report_mismatch("blue_level", m_axis_tdata[23:16], want[23:16]);
					if (m_axis_tdata[31:24] != want[31:24])
						report_mismatch("read_index", m_axis_tdata[31:24], want[31:24]);
				end
			end
		end
	end

	// Receiver readiness: random stalls, or a long hold-off when one is requested.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic test_directed;
		send_beat(rlfe_pkg::CMD_READ, 8'd1, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_READ, 8'd0, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_SET, 8'd0, 8'hFF, 8'h00, 8'h80, 16'd0);
		send_beat(rlfe_pkg::CMD_TICK, '0, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_READ, 8'd16, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_SET, 8'd1, 8'h00, 8'hFF, 8'h01, 16'hFFFF);
		send_beat(rlfe_pkg::CMD_SET, 8'd16, 8'h00, 8'hFF, 8'h7F, 16'd1);
		send_beat(rlfe_pkg::CMD_SET, 8'd2, 8'hFF, 8'hFF, 8'hFF, 16'd3);
		send_beat(rlfe_pkg::CMD_SET, 8'd17, 8'h10, 8'h20, 8'h30, 16'd5);
		send_beat(rlfe_pkg::CMD_SET, 8'd3, 8'hFF, 8'h00, 8'hFF, 16'd1);
		for (int k = 0; k < 4; k++)
			send_beat(rlfe_pkg::CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_beat(rlfe_pkg::CMD_READ, 8'd1, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_READ, 8'd2, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_READ, 8'd3, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_READ, 8'd16, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_READ, 8'd17, '0, '0, '0, '0);
		send_beat(rlfe_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_beat(CMD_UNUSED, 8'd5, 8'hAA, 8'h55, 8'hAA, 16'h5555);
		send_beat(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
	endtask

	// Mostly sets to single LEDs with short fades, ticks and reads; an all-LED
	// set or a full-range beat now and then.
	task automatic test_random(int count);
		int          pick;
		logic [7:0]  idx;
		logic [15:0] ticks;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, NUM_LEDS));
			ticks = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
			if (pick < 25)
				send_beat(rlfe_pkg::CMD_SET, idx, 8'($urandom), 8'($urandom),
					8'($urandom), ticks);
			else if (pick < 60)
				send_beat(rlfe_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 16'($urandom));
			else if (pick < 95)
				send_beat(rlfe_pkg::CMD_READ, idx, 8'($urandom), 8'($urandom),
					8'($urandom), 16'($urandom));
			else
				send_beat(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 16'($urandom));
		end
	endtask

	// The receiver holds off long enough for the input queue to fill and stall.
	task automatic test_backpressure;
		hold_cycles = 400;
		for (int n = 0; n < 8; n++)
			send_beat(rlfe_pkg::CMD_READ, 8'($urandom_range(0, NUM_LEDS)), '0, '0, '0, '0);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		error_count = 0;
		for (int i = 0; i < NUM_LEDS; i++) begin
			remain_q[i] = '0;
			for (int c = 0; c < 3; c++) begin
				level_q[i][c] = '0; target_q[i][c] = '0; step_q[i][c] = '0; frac_q[i][c] = '0;
			end
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		drain();
		test_random(140);
		send_idle_pct = 77;
		test_random(140);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		test_random(140);
		send_idle_pct = 10;
		recv_stall_pct = 10;
		test_random(140);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();

		drain();
		repeat (1000) @(negedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
